FILE: src/ata_pkg.sv
`default_nettype none
package ata_pkg;
  localparam int SampleBits = 16;
  localparam int FracBits = 8;
  localparam int Steps = 30;
  localparam int SumBits = 2 * SampleBits + 1;
  localparam int RadBits = SumBits + 2 * FracBits;
  localparam int MagBits = (RadBits + 1) / 2;
  localparam int CorBits = MagBits + 3;
  localparam int AngBits = 32;
  localparam int CntBits = 11;

  typedef enum logic [1:0] {
    SEL_Z = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_NONE = 2'd3
  } sel_t;

  typedef struct packed {
    logic zero_out;
    logic force_max;
    logic neg;
  } flags_t;

  function automatic logic [AngBits-1:0] atan_rom(input int i);
    logic [AngBits-1:0] r;
    r = '0;
    unique case (i)
      0: r = 32'd843314856;
      1: r = 32'd497837829;
      2: r = 32'd263043836;
      3: r = 32'd133525158;
      4: r = 32'd67021686;
      5: r = 32'd33543515;
      6: r = 32'd16775850;
      7: r = 32'd8388437;
      8: r = 32'd4194282;
      9: r = 32'd2097149;
      10: r = 32'd1048575;
      11: r = 32'd524287;
      12: r = 32'd262143;
      13: r = 32'd131071;
      14: r = 32'd65535;
      15: r = 32'd32767;
      16: r = 32'd16383;
      17: r = 32'd8191;
      18: r = 32'd4095;
      19: r = 32'd2047;
      20: r = 32'd1023;
      21: r = 32'd511;
      22: r = 32'd255;
      23: r = 32'd127;
      24: r = 32'd63;
      25: r = 32'd31;
      26: r = 32'd15;
      27: r = 32'd8;
      28: r = 32'd4;
      29: r = 32'd2;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/accel_tilt_angle.sv
`default_nettype none
// pipeline: front register, square-root stages, CORDIC stages, scale register, output register
// throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or being taken
// reset: rst clears all valid bits; payload registers are not reset
module accel_tilt_angle (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [ata_pkg::SampleBits-1:0] axis_x,
  input  wire logic signed [ata_pkg::SampleBits-1:0] axis_y,
  input  wire logic signed [ata_pkg::SampleBits-1:0] axis_z,
  input  wire logic [1:0] func,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [ata_pkg::CntBits-1:0] tilt_count
);
  import ata_pkg::*;
  localparam int Lat = 1 + MagBits + Steps + 2;
  localparam logic [19:0] Recip = 20'd854890;

  logic en;
  logic [Lat-1:0] vld;
  logic [SumBits-1:0] sum;
  logic [SampleBits:0] cabs0, cabs1;
  flags_t f0, f1, f2, f3;
  logic [MagBits-1:0] root;
  logic signed [AngBits+1:0] ang;
  logic [AngBits-1:0] zc;
  logic [AngBits+17:0] prod;
  logic [19:0] quo_in;
  logic [39:0] quo_prod;
  logic [11:0] quo;
  logic [CntBits-2:0] cnt;

  assign en = !vld[Lat-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_valid};
  end

  ata_front u_front (.clk, .en, .axis_x, .axis_y, .axis_z, .func,
    .sum, .cabs(cabs0), .flags(f0));
  ata_sqrt u_sqrt (.clk, .en, .rad_in({sum, {(2*FracBits){1'b0}}}),
    .cabs_in(cabs0), .flags_in(f0), .root, .cabs_out(cabs1), .flags_out(f1));
  ata_cordic u_cordic (.clk, .en, .y_in(root), .cabs_in(cabs1), .flags_in(f1),
    .ang, .flags_out(f2));

  assign zc = ang[AngBits+1] ? '0 : ang[AngBits-1:0];

  // scale stage: multiply by 180000
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {18'd0, zc} * 50'd180000;
      f3 <= f2;
    end
  end

  // divide by 314*2^30: drop the low 30 bits, then multiply by ceil(2^28/314),
  // exact while the shifted value stays below 2^26
  always_comb begin
    quo_in = prod[AngBits+17:30];
    quo_prod = {20'd0, quo_in} * {20'd0, Recip};
    quo = quo_prod[39:28];
    cnt = (quo > 12'd900) ? 10'd900 : quo[CntBits-2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f3.zero_out) tilt_count <= '0;
      else if (f3.force_max) tilt_count <= 11'sd900;
      else if (f3.neg) tilt_count <= -$signed({1'b0, cnt});
      else tilt_count <= $signed({1'b0, cnt});
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tilt_count))
    else $error("output changed under stall");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tilt_count <= 11'sd900 && tilt_count >= -11'sd900)
    else $error("count out of range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stalled while empty");
`endif
endmodule
`default_nettype wire

FILE: src/ata_front.sv
`default_nettype none
module ata_front (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [ata_pkg::SampleBits-1:0] axis_x,
  input  wire logic signed [ata_pkg::SampleBits-1:0] axis_y,
  input  wire logic signed [ata_pkg::SampleBits-1:0] axis_z,
  input  wire logic [1:0] func,
  output logic [ata_pkg::SumBits-1:0] sum,
  output logic [ata_pkg::SampleBits:0] cabs,
  output ata_pkg::flags_t flags
);
  import ata_pkg::*;
  logic signed [SampleBits-1:0] a, b, c;
  logic [2*SampleBits-1:0] aa, bb;
  logic [SampleBits:0] cmag;
  logic [SumBits-1:0] s;

  always_comb begin
    a = axis_x; b = axis_y; c = axis_z;
    unique case (sel_t'(func))
      SEL_Z: begin a = axis_x; b = axis_y; c = axis_z; end
      SEL_X: begin a = axis_y; b = axis_z; c = axis_x; end
      SEL_Y: begin a = axis_x; b = axis_z; c = axis_y; end
      SEL_NONE: begin a = axis_x; b = axis_y; c = axis_z; end
      default: ;
    endcase
    // squares need the full double width
    aa = $unsigned((2*SampleBits)'(a) * (2*SampleBits)'(a));
    bb = $unsigned((2*SampleBits)'(b) * (2*SampleBits)'(b));
    s = {1'b0, aa} + {1'b0, bb};
    cmag = c[SampleBits-1] ? ({1'b0, ~c} + 1'b1) : {1'b0, c};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= s;
      cabs <= cmag;
      flags.zero_out <= (sel_t'(func) == SEL_NONE) || (s == '0);
      flags.force_max <= (c == '0);
      flags.neg <= c[SampleBits-1];
    end
  end
endmodule
`default_nettype wire

FILE: src/ata_sqrt.sv
`default_nettype none
module ata_sqrt (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [ata_pkg::RadBits-1:0] rad_in,
  input  wire logic [ata_pkg::SampleBits:0] cabs_in,
  input  wire ata_pkg::flags_t flags_in,
  output logic [ata_pkg::MagBits-1:0] root,
  output logic [ata_pkg::SampleBits:0] cabs_out,
  output ata_pkg::flags_t flags_out
);
  import ata_pkg::*;
  // one result bit per stage, restoring
  logic [RadBits+1:0] rem [0:MagBits];
  logic [MagBits-1:0] q [0:MagBits];
  logic [RadBits-1:0] rd [0:MagBits];
  logic [SampleBits:0] cs [0:MagBits];
  flags_t fs [0:MagBits];

  always_comb begin
    rem[0] = '0; q[0] = '0; rd[0] = rad_in; cs[0] = cabs_in; fs[0] = flags_in;
  end

  for (genvar k = 0; k < MagBits; k++) begin : g_st
    localparam int Sh = 2 * (MagBits - 1 - k);
    logic [RadBits+1:0] r2, trial;
    logic [1:0] pair;
    if (Sh + 1 < RadBits) begin : g_pair
      assign pair = rd[k][Sh+1 -: 2];
    end else begin : g_top
      // odd radicand width: the top pair has a single bit
      assign pair = {1'b0, rd[k][Sh]};
    end
    always_comb begin
      r2 = {rem[k][RadBits-1:0], pair};
      trial = {{(RadBits+2-MagBits-2){1'b0}}, q[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= trial) begin
          rem[k+1] <= r2 - trial;
          q[k+1] <= {q[k][MagBits-2:0], 1'b1};
        end else begin
          rem[k+1] <= r2;
          q[k+1] <= {q[k][MagBits-2:0], 1'b0};
        end
        rd[k+1] <= rd[k];
        cs[k+1] <= cs[k];
        fs[k+1] <= fs[k];
      end
    end
  end

  assign root = q[MagBits];
  assign cabs_out = cs[MagBits];
  assign flags_out = fs[MagBits];
endmodule
`default_nettype wire

FILE: src/ata_cordic.sv
`default_nettype none
module ata_cordic (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [ata_pkg::MagBits-1:0] y_in,
  input  wire logic [ata_pkg::SampleBits:0] cabs_in,
  input  wire ata_pkg::flags_t flags_in,
  output logic signed [ata_pkg::AngBits+1:0] ang,
  output ata_pkg::flags_t flags_out
);
  import ata_pkg::*;
  logic signed [CorBits-1:0] x [0:Steps];
  logic signed [CorBits-1:0] y [0:Steps];
  logic signed [AngBits+1:0] z [0:Steps];
  flags_t fs [0:Steps];

  always_comb begin
    x[0] = CorBits'({cabs_in, {FracBits{1'b0}}});
    y[0] = CorBits'(y_in);
    z[0] = '0;
    fs[0] = flags_in;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed({2'b00, atan_rom(i)});
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed({2'b00, atan_rom(i)});
        end
        fs[i+1] <= fs[i];
      end
    end
  end

  assign ang = z[Steps];
  assign flags_out = fs[Steps];
endmodule
`default_nettype wire
